>>> rtl/cjms_pkg.sv
// Shared types, constants and helpers for the coordinated joint motion stepper.
package cjms_pkg;

    localparam int JOINT_COUNT     = 6;
    localparam int BIG_JOINT_COUNT = 3;
    localparam int FRACTION_BITS   = 16;

    localparam int ANGLE_W = 8;
    localparam int LIM_W   = 10;
    localparam int MIN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Joint position and step are Q8.FRACTION_BITS.
    localparam int POS_W  = ANGLE_W + FRACTION_BITS;
    localparam int STEP_W = POS_W;
    // Move time numerator (distance times milliseconds per second).
    localparam int N_W    = POS_W + LIM_W;
    // Serial multiplier product width.
    localparam int MUL_W  = N_W + LIM_W;
    // Divider dividend width.
    localparam int X_W    = MUL_W + FRACTION_BITS;
    // Speed limit times minimum time, and that product in Q form.
    localparam int VM_W   = LIM_W + MIN_W;
    localparam int CMP_W  = VM_W + FRACTION_BITS;

    localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam int SECOND_MS   = 1000;
    localparam int HOME_ANGLE  = 90;
    localparam int LAST_ANGLE  = 73;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOVE   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FREEZE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIG_LIMIT   = 2'd0,
        REG_SMALL_LIMIT = 2'd1,
        REG_PERIOD      = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_TIME,
        ST_CMP_GO,
        ST_CMP_WAIT,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_REPORT
    } t_state;

    // Home pose angle of a joint: the last joint rests lower than the others.
    function automatic logic [ANGLE_W-1:0] start_angle(input int j);
        start_angle = (j == JOINT_COUNT - 1) ? ANGLE_W'(LAST_ANGLE) : ANGLE_W'(HOME_ANGLE);
    endfunction

    // A register written as zero acts as one.
    function automatic logic [LIM_W-1:0] at_least_one(input logic [LIM_W-1:0] v);
        at_least_one = (v == '0) ? LIM_W'(1) : v;
    endfunction

endpackage

>>> rtl/coordinated_joint_motion_stepper_top.sv
// Top level of the coordinated joint motion stepper: sequencer, joint state and ports.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, command fields   | into block
//  out     | o_out_valid / i_out_ready, angles, flags  | out of block
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | into block
//
// A freeze, a no-op or a tick that does not advance passes an accept step and a report
// step; an advancing tick also updates the joints one at a time. A move runs a time
// compare per joint (one 10-bit multiplier pass) and then a step calculation per joint
// (two multiplier passes and a 24-bit divider pass).
// Reset is synchronous and restores the home pose. A new transaction is taken while
// the previous result waits in the output register; a stalled result holds the block
// in its report step until the output register frees.
module coordinated_joint_motion_stepper_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cjms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cjms_pkg::LIM_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cjms_pkg::CMD_W-1:0]         i_command,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_base,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_shoulder,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_elbow,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_wrist,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_wrist_roll,
    input  logic [cjms_pkg::ANGLE_W-1:0]       i_target_gripper,
    input  logic [cjms_pkg::MIN_W-1:0]         i_min_time_ms,
    input  logic [cjms_pkg::TIME_W-1:0]        i_now_ms,
    input  logic                               i_freeze_flag,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_base,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_shoulder,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_elbow,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_wrist,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_wrist_roll,
    output logic [cjms_pkg::ANGLE_W-1:0]       o_angle_gripper,
    output logic                               o_moving,
    output logic                               o_servo_updated
);

    localparam int JC = cjms_pkg::JOINT_COUNT;
    localparam int F  = cjms_pkg::FRACTION_BITS;
    localparam logic [cjms_pkg::JIDX_W-1:0] LAST_J = cjms_pkg::JIDX_W'(JC - 1);

    cjms_pkg::t_state r_state, n_state;

    logic [cjms_pkg::LIM_W-1:0]   r_big_lim, r_small_lim, r_period;
    logic [cjms_pkg::POS_W-1:0]   r_pos    [JC];
    logic [cjms_pkg::STEP_W-1:0]  r_step   [JC];
    logic [cjms_pkg::ANGLE_W-1:0] r_tgt    [JC];
    logic [cjms_pkg::TIME_W-1:0]  r_next_time;
    logic                         r_frozen;
    logic [cjms_pkg::JIDX_W-1:0]  r_j;
    logic [cjms_pkg::MIN_W-1:0]   r_min;
    logic                         r_upd;
    logic [cjms_pkg::N_W-1:0]     r_cand_n, r_best_n;
    logic [cjms_pkg::LIM_W-1:0]   r_cand_dn, r_best_dn;
    logic [cjms_pkg::ANGLE_W-1:0] r_out_ang [JC];
    logic                         r_out_valid, r_out_moving, r_out_upd;

    logic [cjms_pkg::ANGLE_W-1:0] in_tgt [JC];
    logic                         in_acc, slot_free, any_moving, tick_due, last_joint;
    logic                         in_ready, mul_start, div_start;
    cjms_pkg::t_cmd               in_cmd;

    // Joint arithmetic for the joint under the index.
    logic [cjms_pkg::POS_W-1:0]   cur_pos, cur_tgt, cur_d;
    logic [cjms_pkg::STEP_W-1:0]  cur_step;
    logic [cjms_pkg::LIM_W-1:0]   cur_v, period_eff;
    logic [cjms_pkg::N_W-1:0]     d1000;
    logic [cjms_pkg::VM_W-1:0]    vm;
    logic                         keeps_min;
    logic [cjms_pkg::POS_W:0]     up_sum, dn_lim;
    logic [cjms_pkg::STEP_W-1:0]  new_step;

    logic [cjms_pkg::MUL_W-1:0]   mul0_a, mul1_a, mul0_p, mul1_p;
    logic [cjms_pkg::LIM_W-1:0]   mul0_b, mul1_b;
    logic                         mul0_done, mul1_done, div_done;
    logic [cjms_pkg::STEP_W-1:0]  div_q;

    assign in_tgt[0] = i_target_base;
    assign in_tgt[1] = i_target_shoulder;
    assign in_tgt[2] = i_target_elbow;
    assign in_tgt[3] = i_target_wrist;
    assign in_tgt[4] = i_target_wrist_roll;
    assign in_tgt[5] = i_target_gripper;

    assign in_cmd     = cjms_pkg::t_cmd'(i_command);
    assign in_acc     = i_in_valid && in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign tick_due   = (i_now_ms >= r_next_time);
    assign last_joint = (r_j == LAST_J);
    assign period_eff = cjms_pkg::at_least_one(r_period);

    always_comb begin
        any_moving = 1'b0;
        for (int k = 0; k < JC; k++) begin
            any_moving = any_moving || (r_step[k] != '0);
        end
    end

    // Distance, speed limit and joint time candidate for the indexed joint.
    assign cur_pos  = r_pos[r_j];
    assign cur_tgt  = {r_tgt[r_j], {F{1'b0}}};
    assign cur_step = r_step[r_j];
    assign cur_d    = (cur_pos > cur_tgt) ? (cur_pos - cur_tgt) : (cur_tgt - cur_pos);
    assign cur_v    = cjms_pkg::at_least_one((int'(r_j) < cjms_pkg::BIG_JOINT_COUNT)
                                             ? r_big_lim : r_small_lim);
    assign d1000    = cjms_pkg::N_W'(cur_d) * cjms_pkg::N_W'(cjms_pkg::SECOND_MS);
    assign vm       = cjms_pkg::VM_W'(cur_v) * cjms_pkg::VM_W'(r_min);
    assign keeps_min = (r_min != '0) &&
                       (cjms_pkg::CMP_W'(d1000) <= (cjms_pkg::CMP_W'(vm) << F));

    // Tick update terms.
    assign up_sum = {1'b0, cur_pos} + {1'b0, cur_step};
    assign dn_lim = {1'b0, cur_tgt} + {1'b0, cur_step};

    // Step from the quotient: zero with no time or no distance, at least one LSB else.
    always_comb begin
        if (r_best_n == '0 || cur_d == '0) begin
            new_step = '0;
        end else if (div_q == '0) begin
            new_step = cjms_pkg::STEP_W'(1);
        end else begin
            new_step = div_q;
        end
    end

    // Operand selection for the two multiplier lanes.
    always_comb begin
        mul0_a = cjms_pkg::MUL_W'(r_cand_n);
        mul0_b = r_best_dn;
        mul1_a = cjms_pkg::MUL_W'(r_best_n);
        mul1_b = r_cand_dn;
        if (r_state == cjms_pkg::ST_MUL1_GO) begin
            mul0_a = cjms_pkg::MUL_W'(cur_d);
            mul0_b = period_eff;
        end else if (r_state == cjms_pkg::ST_MUL2_GO) begin
            mul0_a = mul0_p;
            mul0_b = r_best_dn;
        end
    end

    cjms_sermul u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul0_a),
        .i_b     (mul0_b),
        .o_done  (mul0_done),
        .o_prod  (mul0_p)
    );

    cjms_sermul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul1_a),
        .i_b     (mul1_b),
        .o_done  (mul1_done),
        .o_prod  (mul1_p)
    );

    cjms_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({mul0_p, {F{1'b0}}}),
        .i_den   (r_best_n),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cjms_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        cjms_pkg::CMD_MOVE: n_state = cjms_pkg::ST_TIME;
                        cjms_pkg::CMD_TICK: n_state = (tick_due && !r_frozen && any_moving)
                                                      ? cjms_pkg::ST_TICK
                                                      : cjms_pkg::ST_REPORT;
                        default:            n_state = cjms_pkg::ST_REPORT;
                    endcase
                end
            end
            cjms_pkg::ST_TICK:      n_state = last_joint ? cjms_pkg::ST_REPORT
                                                         : cjms_pkg::ST_TICK;
            cjms_pkg::ST_TIME:      n_state = cjms_pkg::ST_CMP_GO;
            cjms_pkg::ST_CMP_GO:    n_state = cjms_pkg::ST_CMP_WAIT;
            cjms_pkg::ST_CMP_WAIT: begin
                if (mul0_done && mul1_done) begin
                    n_state = last_joint ? cjms_pkg::ST_MUL1_GO : cjms_pkg::ST_TIME;
                end
            end
            cjms_pkg::ST_MUL1_GO:   n_state = cjms_pkg::ST_MUL1_WAIT;
            cjms_pkg::ST_MUL1_WAIT: if (mul0_done) n_state = cjms_pkg::ST_MUL2_GO;
            cjms_pkg::ST_MUL2_GO:   n_state = cjms_pkg::ST_MUL2_WAIT;
            cjms_pkg::ST_MUL2_WAIT: if (mul0_done) n_state = cjms_pkg::ST_DIV_GO;
            cjms_pkg::ST_DIV_GO:    n_state = cjms_pkg::ST_DIV_WAIT;
            cjms_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = last_joint ? cjms_pkg::ST_REPORT : cjms_pkg::ST_MUL1_GO;
                end
            end
            cjms_pkg::ST_REPORT:    if (slot_free) n_state = cjms_pkg::ST_IDLE;
            default:                n_state = cjms_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            cjms_pkg::ST_IDLE:    in_ready  = 1'b1;
            cjms_pkg::ST_CMP_GO,
            cjms_pkg::ST_MUL1_GO,
            cjms_pkg::ST_MUL2_GO: mul_start = 1'b1;
            cjms_pkg::ST_DIV_GO:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cjms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration, joint state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_lim   <= cjms_pkg::LIM_W'(60);
            r_small_lim <= cjms_pkg::LIM_W'(100);
            r_period    <= cjms_pkg::LIM_W'(20);
            for (int k = 0; k < JC; k++) begin
                r_tgt[k]  <= cjms_pkg::start_angle(k);
                r_pos[k]  <= {cjms_pkg::start_angle(k), {F{1'b0}}};
                r_step[k] <= '0;
            end
            r_next_time <= '0;
            r_frozen    <= 1'b0;
            r_j         <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (cjms_pkg::t_reg_idx'(i_cfg_index))
                    cjms_pkg::REG_BIG_LIMIT:   r_big_lim   <= i_cfg_data;
                    cjms_pkg::REG_SMALL_LIMIT: r_small_lim <= i_cfg_data;
                    cjms_pkg::REG_PERIOD:      r_period    <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                cjms_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_j   <= '0;
                        r_upd <= 1'b0;
                        case (in_cmd)
                            cjms_pkg::CMD_MOVE: begin
                                for (int k = 0; k < JC; k++) begin
                                    r_tgt[k] <= in_tgt[k];
                                end
                                r_min     <= i_min_time_ms;
                                r_best_n  <= '0;
                                r_best_dn <= cjms_pkg::LIM_W'(1);
                            end
                            cjms_pkg::CMD_TICK: begin
                                if (tick_due) begin
                                    r_next_time <= i_now_ms + cjms_pkg::TIME_W'(period_eff);
                                    r_upd       <= !r_frozen && any_moving;
                                end
                            end
                            cjms_pkg::CMD_FREEZE: r_frozen <= i_freeze_flag;
                            default: ;
                        endcase
                    end
                end
                cjms_pkg::ST_TICK: begin
                    if (cur_pos < cur_tgt) begin
                        r_pos[r_j] <= (up_sum < {1'b0, cur_tgt}) ? up_sum[cjms_pkg::POS_W-1:0]
                                                                 : cur_tgt;
                    end else if (cur_pos > cur_tgt) begin
                        r_pos[r_j] <= ({1'b0, cur_pos} > dn_lim) ? (cur_pos - cur_step)
                                                                 : cur_tgt;
                    end else begin
                        r_step[r_j] <= '0;
                    end
                    r_j <= r_j + cjms_pkg::JIDX_W'(1);
                end
                cjms_pkg::ST_TIME: begin
                    r_cand_n  <= keeps_min ? cjms_pkg::N_W'({r_min, {F{1'b0}}}) : d1000;
                    r_cand_dn <= keeps_min ? cjms_pkg::LIM_W'(1) : cur_v;
                end
                cjms_pkg::ST_CMP_WAIT: begin
                    if (mul0_done && mul1_done) begin
                        if (mul0_p > mul1_p) begin
                            r_best_n  <= r_cand_n;
                            r_best_dn <= r_cand_dn;
                        end
                        r_j <= last_joint ? '0 : (r_j + cjms_pkg::JIDX_W'(1));
                    end
                end
                cjms_pkg::ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_step[r_j] <= new_step;
                        r_j <= r_j + cjms_pkg::JIDX_W'(1);
                    end
                end
                default: ;
            endcase

            // Output register: freed by the consumer, loaded at the end of an item.
            if (r_state == cjms_pkg::ST_REPORT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == cjms_pkg::ST_REPORT && slot_free) begin
            for (int k = 0; k < JC; k++) begin
                r_out_ang[k] <= r_pos[k][cjms_pkg::POS_W-1:F];
            end
            r_out_moving <= any_moving;
            r_out_upd    <= r_upd;
        end
    end

    assign o_in_ready         = in_ready;
    assign o_out_valid        = r_out_valid;
    assign o_angle_base       = r_out_ang[0];
    assign o_angle_shoulder   = r_out_ang[1];
    assign o_angle_elbow      = r_out_ang[2];
    assign o_angle_wrist      = r_out_ang[3];
    assign o_angle_wrist_roll = r_out_ang[4];
    assign o_angle_gripper    = r_out_ang[5];
    assign o_moving           = r_out_moving;
    assign o_servo_updated    = r_out_upd;

endmodule

>>> rtl/cjms_sermul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module cjms_sermul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cjms_pkg::MUL_W-1:0]   i_a,
    input  logic [cjms_pkg::LIM_W-1:0]   i_b,
    output logic                         o_done,
    output logic [cjms_pkg::MUL_W-1:0]   o_prod
);

    localparam int CNT_W = $clog2(cjms_pkg::LIM_W + 1);

    logic [cjms_pkg::MUL_W-1:0] r_a;
    logic [cjms_pkg::LIM_W-1:0] r_b;
    logic [cjms_pkg::MUL_W-1:0] r_p;
    logic [CNT_W-1:0]           r_cnt;

    // Control: count of multiplier bits still to consume.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(cjms_pkg::LIM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Datapath: add the shifted multiplicand for each set multiplier bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_cnt != '0) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_prod = r_p;

endmodule

>>> rtl/cjms_serdiv.sv
// Restoring divider, one quotient bit per cycle, saturating to the step width.
module cjms_serdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cjms_pkg::X_W-1:0]     i_num,
    input  logic [cjms_pkg::N_W-1:0]     i_den,
    output logic                         o_done,
    output logic [cjms_pkg::STEP_W-1:0]  o_quot
);

    localparam int Q_W   = cjms_pkg::STEP_W;
    localparam int REM_W = cjms_pkg::X_W - Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [REM_W-1:0]         r_rem;
    logic [Q_W-1:0]           r_low;
    logic [cjms_pkg::N_W-1:0] r_den;
    logic                     r_sat;
    logic [CNT_W-1:0]         r_cnt;

    logic [REM_W:0] trial;
    logic           fits;

    // Partial remainder with the next dividend bit brought down.
    assign trial = {r_rem, r_low[Q_W-1]};
    assign fits  = (trial >= (REM_W+1)'(r_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // The low dividend bits shift out while the quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= (i_num >= (cjms_pkg::X_W'(i_den) << Q_W));
            r_rem <= i_num[cjms_pkg::X_W-1:Q_W];
            r_low <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= REM_W'(trial - (REM_W+1)'(r_den));
            end else begin
                r_rem <= trial[REM_W-1:0];
            end
            r_low <= {r_low[Q_W-2:0], fits};
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quot = r_sat ? {Q_W{1'b1}} : r_low;

endmodule

>>> bench/cjms_checker.sv
// Checker for the joint motion stepper: predicts every report and compares it.
`timescale 1ns / 1ps

module cjms_checker
    import cjms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [LIM_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [ANGLE_W-1:0]     i_target_base,
    input  logic [ANGLE_W-1:0]     i_target_shoulder,
    input  logic [ANGLE_W-1:0]     i_target_elbow,
    input  logic [ANGLE_W-1:0]     i_target_wrist,
    input  logic [ANGLE_W-1:0]     i_target_wrist_roll,
    input  logic [ANGLE_W-1:0]     i_target_gripper,
    input  logic [MIN_W-1:0]       i_min_time_ms,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic                   i_freeze_flag,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [ANGLE_W-1:0]     i_angle_base,
    input  logic [ANGLE_W-1:0]     i_angle_shoulder,
    input  logic [ANGLE_W-1:0]     i_angle_elbow,
    input  logic [ANGLE_W-1:0]     i_angle_wrist,
    input  logic [ANGLE_W-1:0]     i_angle_wrist_roll,
    input  logic [ANGLE_W-1:0]     i_angle_gripper,
    input  logic                   i_moving,
    input  logic                   i_servo_updated,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [ANGLE_W-1:0] a0, a1, a2, a3, a4, a5;
        logic               moving;
        logic               updated;
    } t_report;

    // Predicted copy of the block's registers and joint state.
    logic [LIM_W-1:0]   big_limit, small_limit, period_ms;
    logic [POS_W-1:0]   position [JOINT_COUNT];
    logic [STEP_W-1:0]  step     [JOINT_COUNT];
    logic [ANGLE_W-1:0] target   [JOINT_COUNT];
    logic [TIME_W-1:0]  due_time;
    logic               halted;

    t_report expected_reports[$];
    int      mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_reports.size();

    function automatic longint unsigned lim1(input logic [LIM_W-1:0] v);
        return (v == 0) ? 64'd1 : 64'(v);
    endfunction

    function automatic longint unsigned gap_of(input int j);
        longint unsigned goal, here;
        goal = 64'(target[j]) << FRACTION_BITS;
        here = 64'(position[j]);
        return (here > goal) ? here - goal : goal - here;
    endfunction

    function automatic logic any_step();
        for (int j = 0; j < JOINT_COUNT; j++)
            if (step[j] != 0) return 1'b1;
        return 1'b0;
    endfunction

    // Applies one accepted transaction to the predicted state and returns its report.
    function automatic t_report motion_predict(input t_cmd cmd, input logic [47:0] goals,
                                               input logic [MIN_W-1:0] min_ms,
                                               input logic [TIME_W-1:0] now,
                                               input logic freeze);
        longint unsigned tn, td, n, dd, d, v, s, goal, here;
        logic advanced;
        t_report r;
        advanced = 1'b0;
        if (cmd == CMD_MOVE) begin
            for (int j = 0; j < JOINT_COUNT; j++)
                target[j] = goals[8*j +: 8];
            tn = 0;
            td = 1;
            // The slowest joint sets the common move time.
            for (int j = 0; j < JOINT_COUNT; j++) begin
                d = gap_of(j);
                v = lim1(j < BIG_JOINT_COUNT ? big_limit : small_limit);
                if (min_ms != 0 && d * SECOND_MS <= ((v * min_ms) << FRACTION_BITS)) begin
                    n  = min_ms;
                    dd = 1;
                end else begin
                    n  = d * SECOND_MS;
                    dd = v << FRACTION_BITS;
                end
                if (n * td > tn * dd) begin
                    tn = n;
                    td = dd;
                end
            end
            for (int j = 0; j < JOINT_COUNT; j++) begin
                d = gap_of(j);
                s = 0;
                if (tn != 0 && d != 0) begin
                    s = (d * lim1(period_ms) * td) / tn;
                    if (s == 0) s = 1;
                    if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
                end
                step[j] = STEP_W'(s);
            end
        end else if (cmd == CMD_TICK) begin
            if (now >= due_time) begin
                if (!halted && any_step()) begin
                    for (int j = 0; j < JOINT_COUNT; j++) begin
                        goal = 64'(target[j]) << FRACTION_BITS;
                        here = 64'(position[j]);
                        if (here < goal)
                            here = (here + step[j] < goal) ? here + step[j] : goal;
                        else if (here > goal)
                            here = (here > goal + step[j]) ? here - step[j] : goal;
                        else
                            step[j] = '0;
                        position[j] = POS_W'(here);
                    end
                    advanced = 1'b1;
                end
                due_time = now + TIME_W'(lim1(period_ms));
            end
        end else if (cmd == CMD_FREEZE) begin
            halted = freeze;
        end
        r.a0 = position[0][POS_W-1 -: ANGLE_W];
        r.a1 = position[1][POS_W-1 -: ANGLE_W];
        r.a2 = position[2][POS_W-1 -: ANGLE_W];
        r.a3 = position[3][POS_W-1 -: ANGLE_W];
        r.a4 = position[4][POS_W-1 -: ANGLE_W];
        r.a5 = position[5][POS_W-1 -: ANGLE_W];
        r.moving  = any_step();
        r.updated = advanced;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Transactions in, then results out, on every clock edge.
    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            big_limit   <= 10'd60;
            small_limit <= 10'd100;
            period_ms   <= 10'd20;
            for (int j = 0; j < JOINT_COUNT; j++) begin
                position[j] = POS_W'(start_angle(j)) << FRACTION_BITS;
                step[j]     = '0;
                target[j]   = start_angle(j);
            end
            due_time = '0;
            halted   = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_BIG_LIMIT:   big_limit   <= i_cfg_data;
                    REG_SMALL_LIMIT: small_limit <= i_cfg_data;
                    REG_PERIOD:      period_ms   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_reports.push_back(motion_predict(t_cmd'(i_command),
                    {i_target_gripper, i_target_wrist_roll, i_target_wrist,
                     i_target_elbow, i_target_shoulder, i_target_base},
                    i_min_time_ms, i_now_ms, i_freeze_flag));
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with no transaction waiting", 32'd1, 32'd0);
                end else begin
                    want = expected_reports.pop_front();
                    if (i_angle_base !== want.a0)
                        report_mismatch("angle_base", i_angle_base, want.a0);
                    if (i_angle_shoulder !== want.a1)
                        report_mismatch("angle_shoulder", i_angle_shoulder, want.a1);
                    if (i_angle_elbow !== want.a2)
                        report_mismatch("angle_elbow", i_angle_elbow, want.a2);
                    if (i_angle_wrist !== want.a3)
                        report_mismatch("angle_wrist", i_angle_wrist, want.a3);
                    if (i_angle_wrist_roll !== want.a4)
                        report_mismatch("angle_wrist_roll", i_angle_wrist_roll, want.a4);
                    if (i_angle_gripper !== want.a5)
                        report_mismatch("angle_gripper", i_angle_gripper, want.a5);
                    if (i_moving !== want.moving)
                        report_mismatch("moving", i_moving, want.moving);
                    if (i_servo_updated !== want.updated)
                        report_mismatch("servo_updated", i_servo_updated, want.updated);
                end
            end
        end
    end

endmodule

>>> bench/tb_coordinated_joint_motion_stepper_top.sv
// Testbench top for the joint motion stepper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_coordinated_joint_motion_stepper_top;
    import cjms_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LIM_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command = CMD_NONE;
    logic [ANGLE_W-1:0]   i_target_base = '0, i_target_shoulder = '0, i_target_elbow = '0;
    logic [ANGLE_W-1:0]   i_target_wrist = '0, i_target_wrist_roll = '0;
    logic [ANGLE_W-1:0]   i_target_gripper = '0;
    logic [MIN_W-1:0]     i_min_time_ms = '0;
    logic [TIME_W-1:0]    i_now_ms = '0;
    logic                 i_freeze_flag = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ANGLE_W-1:0]   o_angle_base, o_angle_shoulder, o_angle_elbow;
    logic [ANGLE_W-1:0]   o_angle_wrist, o_angle_wrist_roll, o_angle_gripper;
    logic                 o_moving, o_servo_updated;
    int                   fail_count, pending;

    int                   burst_left = 0;
    logic                 valid_held = 1'b0;
    logic [TIME_W-1:0]    clock_ms = '0;
    int                   tick_period = 20;

    always #5 i_clk = ~i_clk;

    coordinated_joint_motion_stepper_top dut (.*);

    cjms_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_command,
        .i_target_base, .i_target_shoulder, .i_target_elbow, .i_target_wrist,
        .i_target_wrist_roll, .i_target_gripper, .i_min_time_ms, .i_now_ms, .i_freeze_flag,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_angle_base(o_angle_base), .i_angle_shoulder(o_angle_shoulder),
        .i_angle_elbow(o_angle_elbow), .i_angle_wrist(o_angle_wrist),
        .i_angle_wrist_roll(o_angle_wrist_roll), .i_angle_gripper(o_angle_gripper),
        .i_moving(o_moving), .i_servo_updated(o_servo_updated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side stalls in phases: some free-running, some heavily stalled.
    always @(posedge i_clk) begin
        int stall_pct;
        if ($urandom_range(0, 199) == 0)
            stall_pct = $urandom_range(0, 3) * 25;
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offers one transaction and waits for the edge that accepts it; after a burst it idles first.
    task automatic send_item(input t_cmd cmd, input logic [47:0] goals,
                             input logic [MIN_W-1:0] min_ms, input logic [TIME_W-1:0] now,
                             input logic freeze);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        {i_target_gripper, i_target_wrist_roll, i_target_wrist,
         i_target_elbow, i_target_shoulder, i_target_base} <= goals;
        i_min_time_ms <= min_ms;
        i_now_ms <= now;
        i_freeze_flag <= freeze;
        valid_held = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // Bursts of back-to-back transactions separated by idle gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic tick_at(input logic [TIME_W-1:0] now);
        send_item(CMD_TICK, 48'($urandom()) ^ {16'($urandom()), 32'd0}, 16'($urandom()),
                  now, 1'($urandom()));
    endtask

    function automatic logic [47:0] random_goals();
        logic [47:0] g;
        for (int j = 0; j < JOINT_COUNT; j++)
            g[8*j +: 8] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(181, 255))
                                                       : 8'($urandom_range(0, 180));
        return g;
    endfunction

    // Waits until every result is back, then gives the block time to settle.
    task automatic wait_quiet();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [LIM_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_PERIOD) tick_period = (value == 0) ? 1 : value;
    endtask

    // Random phase: mostly ticks that drive motion forward, with moves, freezes and no-ops mixed in.
    task automatic random_phase(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 9) begin
                case ($urandom_range(0, 3))
                    0: send_item(CMD_MOVE, random_goals(), '0, 32'($urandom()), 1'($urandom()));
                    1: send_item(CMD_MOVE, random_goals(), 16'($urandom_range(1, 3000)),
                                 32'($urandom()), 1'($urandom()));
                    2: send_item(CMD_MOVE, random_goals(), 16'($urandom()),
                                 32'($urandom()), 1'($urandom()));
                    default: send_item(CMD_MOVE, 48'($urandom()) ^ {16'($urandom()), 32'd0},
                                       16'($urandom_range(0, 50)), 32'($urandom()),
                                       1'($urandom()));
                endcase
            end else if (pick < 13) begin
                send_item(CMD_FREEZE, random_goals(), 16'($urandom()), 32'($urandom()),
                          ($urandom_range(0, 3) == 0));
            end else if (pick < 15) begin
                send_item(CMD_NONE, random_goals(), 16'($urandom()), 32'($urandom()),
                          1'($urandom()));
            end else begin
                if ($urandom_range(0, 49) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, 2 * tick_period);
                tick_at(clock_ms);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: report-only, idle ticks, freeze, extreme targets and times.
        send_item(CMD_NONE, '0, '0, '0, 1'b0);
        tick_at(32'd0);
        tick_at(32'd5);
        send_item(CMD_MOVE, {8'd73, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90}, '0, '0, 1'b0);
        send_item(CMD_MOVE, {8'd73, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90}, 16'd500, '0, 1'b0);
        send_item(CMD_MOVE, {8'd180, 8'd0, 8'd180, 8'd0, 8'd255, 8'd0}, '0, '0, 1'b0);
        tick_at(32'd20);
        tick_at(32'd30);
        send_item(CMD_FREEZE, '0, '0, '0, 1'b1);
        tick_at(32'd40);
        send_item(CMD_FREEZE, '1, '1, '1, 1'b0);
        tick_at(32'd60);
        send_item(CMD_MOVE, {8'd91, 8'd0, 8'd255, 8'd180, 8'd1, 8'd255}, 16'hFFFF, '0, 1'b0);
        tick_at(32'd80);
        send_item(CMD_MOVE, {8'd0, 8'd180, 8'd0, 8'd255, 8'd180, 8'd0}, 16'd1, '0, 1'b0);
        for (int k = 0; k < 4; k++) tick_at(32'd100 + 20 * k);
        tick_at(32'hFFFF_FFFF);
        tick_at(32'd0);
        wait_quiet();

        // Phases across the register settings, extremes included.
        write_reg(REG_BIG_LIMIT, 10'd1000);
        write_reg(REG_SMALL_LIMIT, 10'd1000);
        write_reg(REG_PERIOD, 10'd1000);
        write_reg(REG_UNUSED, 10'h3FF);
        clock_ms = 32'hFFFF_0000;
        random_phase(400);
        wait_quiet();
        write_reg(REG_BIG_LIMIT, 10'd0);
        write_reg(REG_SMALL_LIMIT, 10'd1);
        write_reg(REG_PERIOD, 10'd0);
        random_phase(300);
        wait_quiet();
        write_reg(REG_BIG_LIMIT, 10'h3FF);
        write_reg(REG_SMALL_LIMIT, 10'd37);
        write_reg(REG_PERIOD, 10'd250);
        random_phase(500);
        wait_quiet();
        write_reg(REG_BIG_LIMIT, 10'($urandom_range(1, 1000)));
        write_reg(REG_SMALL_LIMIT, 10'($urandom_range(1, 1000)));
        write_reg(REG_PERIOD, 10'($urandom_range(1, 60)));
        random_phase(530);
        wait_quiet();
        repeat (400) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/cjms_pkg.sv
rtl/cjms_sermul.sv
rtl/cjms_serdiv.sv
rtl/coordinated_joint_motion_stepper_top.sv
bench/cjms_checker.sv
bench/tb_coordinated_joint_motion_stepper_top.sv
